// ===== sv/ascii_command_line_parser_top_macros.svh =====
// assertion macros shared by the checker
`ifndef ASCII_COMMAND_LINE_PARSER_TOP_MACROS_SVH
`define ASCII_COMMAND_LINE_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CLP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clp check failed");

// next-cycle implication, disabled while reset is high
`define CLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clp check failed");

`endif

// ===== sv/clp_pkg.sv =====
`timescale 1ns / 1ps
package clp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [2:0]  command_kind;
    logic [13:0] command_value;
  } out_t;

  typedef enum logic [2:0] {
    OP_OTHER = 3'd0,
    OP_S     = 3'd1,
    OP_T     = 3'd2,
    OP_C     = 3'd3,
    OP_E     = 3'd4,
    OP_R     = 3'd5
  } op_class_t;

  // classified character passed from front to back
  typedef struct packed {
    logic       is_op;
    op_class_t  op_class;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } token_t;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_SYNC_ON   = 3'd1;
  localparam logic [2:0] KIND_SYNC_OFF  = 3'd2;
  localparam logic [2:0] KIND_CAM_ON    = 3'd3;
  localparam logic [2:0] KIND_CAM_OFF   = 3'd4;
  localparam logic [2:0] KIND_RATE      = 3'd5;
  localparam logic [2:0] KIND_EVENT     = 3'd6;
  localparam logic [2:0] KIND_REWARD    = 3'd7;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [13:0] ARG_SAT    = 14'd10001;
  localparam logic [13:0] RATE_MAX   = 14'd500;
  localparam logic [13:0] EVENT_MAX  = 14'd255;
  localparam logic [13:0] REWARD_MAX = 14'd10000;
  localparam logic [1:0]  COUNT_MAX  = 2'd3;

  function automatic op_class_t classify(input logic [7:0] c);
    op_class_t r;
    case (c)
      CHAR_S:  r = OP_S;
      CHAR_T:  r = OP_T;
      CHAR_C:  r = OP_C;
      CHAR_E:  r = OP_E;
      CHAR_R:  r = OP_R;
      default: r = OP_OTHER;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/clp_fifo.sv =====
`timescale 1ns / 1ps
module clp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  clp_pkg::token_t wr_data,
  input  logic            rd,
  output clp_pkg::token_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clp_pkg::token_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== sv/clp_front.sv =====
`timescale 1ns / 1ps
module clp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clp_pkg::in_t    in_item,
  input  logic            q_full,
  output logic            q_wr,
  output clp_pkg::token_t token
);

  logic at_line_start;

  assign q_wr = push && !q_full;

  always_comb begin
    token.is_op    = at_line_start;
    token.op_class = clp_pkg::classify(in_item.char_code);
    token.is_digit = (in_item.char_code >= clp_pkg::CHAR_ZERO) &&
                     (in_item.char_code <= clp_pkg::CHAR_NINE);
    token.digit    = 4'(in_item.char_code - clp_pkg::CHAR_ZERO);
    token.last     = in_item.last_char;
  end

  // first character of every line is the opcode
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
    end else if (q_wr) begin
      at_line_start <= in_item.last_char;
    end
  end

endmodule

// ===== sv/clp_back.sv =====
`timescale 1ns / 1ps
module clp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  input  clp_pkg::token_t token,
  output logic            tok_take,
  input  logic            pop,
  output logic            empty,
  output clp_pkg::out_t   out_item
);

  clp_pkg::op_class_t opcode_class, opcode_class_next;
  logic [13:0] arg_value, arg_value_next;
  logic [1:0]  arg_count, arg_count_next;
  logic        non_digit_seen, non_digit_seen_next;
  logic        out_valid;
  logic [16:0] nv;
  logic        one_char;
  logic        num_ok;
  clp_pkg::out_t result;

  // a line end needs the output slot; other characters always go through
  assign tok_take = tok_valid && (!token.last || !out_valid || pop);
  assign empty    = !out_valid;

  // times ten plus digit, as two shifts and adds
  assign nv = 17'({arg_value, 3'b000}) + 17'({arg_value, 1'b0}) + 17'(token.digit);

  always_comb begin
    opcode_class_next   = opcode_class;
    arg_value_next      = arg_value;
    arg_count_next      = arg_count;
    non_digit_seen_next = non_digit_seen;
    if (token.is_op) begin
      opcode_class_next   = token.op_class;
      arg_value_next      = '0;
      arg_count_next      = '0;
      non_digit_seen_next = 1'b0;
    end else begin
      if (arg_count != clp_pkg::COUNT_MAX) begin
        arg_count_next = arg_count + 2'd1;
      end
      if (!token.is_digit) begin
        non_digit_seen_next = 1'b1;
      end else if (nv > 17'(clp_pkg::ARG_SAT)) begin
        arg_value_next = clp_pkg::ARG_SAT;
      end else begin
        arg_value_next = nv[13:0];
      end
    end
  end

  always_comb begin
    one_char = (arg_count_next == 2'd1) && !non_digit_seen_next;
    num_ok   = (arg_count_next != 2'd0) && !non_digit_seen_next;
    result.command_kind  = clp_pkg::KIND_NONE;
    result.command_value = '0;
    case (opcode_class_next)
      clp_pkg::OP_S: begin
        if (one_char && arg_value_next == 14'd1) begin
          result.command_kind = clp_pkg::KIND_SYNC_ON;
        end else if (one_char && arg_value_next == 14'd0) begin
          result.command_kind = clp_pkg::KIND_SYNC_OFF;
        end
      end
      clp_pkg::OP_T: begin
        if (one_char && arg_value_next == 14'd1) begin
          result.command_kind = clp_pkg::KIND_CAM_ON;
        end else if (one_char && arg_value_next == 14'd0) begin
          result.command_kind = clp_pkg::KIND_CAM_OFF;
        end
      end
      clp_pkg::OP_C: begin
        if (num_ok && arg_value_next != 14'd0 && arg_value_next <= clp_pkg::RATE_MAX) begin
          result.command_kind  = clp_pkg::KIND_RATE;
          result.command_value = arg_value_next;
        end
      end
      clp_pkg::OP_E: begin
        if (num_ok && arg_value_next <= clp_pkg::EVENT_MAX) begin
          result.command_kind  = clp_pkg::KIND_EVENT;
          result.command_value = arg_value_next;
        end
      end
      clp_pkg::OP_R: begin
        if (num_ok && arg_value_next != 14'd0 && arg_value_next <= clp_pkg::REWARD_MAX) begin
          result.command_kind  = clp_pkg::KIND_REWARD;
          result.command_value = arg_value_next;
        end
      end
      default: begin
        result.command_kind = clp_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_class   <= clp_pkg::OP_OTHER;
      arg_value      <= '0;
      arg_count      <= '0;
      non_digit_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (tok_take) begin
        opcode_class   <= opcode_class_next;
        arg_value      <= arg_value_next;
        arg_count      <= arg_count_next;
        non_digit_seen <= non_digit_seen_next;
      end
      if (tok_take && token.last) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && token.last) begin
      out_item <= result;
    end
  end

endmodule

// ===== sv/ascii_command_line_parser_top.sv =====
`timescale 1ns / 1ps
// ascii command line parser
// input channel: one character per transaction (push / full), with last_char
//   set on the final character of a line; empty lines are never presented
// result channel: one command per line (empty / pop); the oldest command sits
//   on out_item while empty is low and leaves on a pop
// a line end passes through the token queue and then the back end's output
//   register before its command is shown on out_item and can be popped
// throughput: one character per cycle while full is low; set by the single accumulate
//   (value times ten plus digit) and decode done in the back end per token
// the front end tags each character as opcode or argument and classifies it,
//   then writes it into a FIFO_DEPTH entry token queue
// the back end drains the queue, keeps the running argument and emits the
//   command into a one-entry output register
// receiver stall: argument characters keep draining; a line end waits in the
//   queue until the output register is free, and push sees full once the
//   queue fills
// reset: synchronous, clears the queue, the output register and any partial
//   line; the next character after reset is an opcode
module ascii_command_line_parser_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  clp_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output clp_pkg::out_t out_item
);

  clp_pkg::token_t wr_token;
  clp_pkg::token_t rd_token;
  logic            q_wr;
  logic            q_rd;
  logic            q_full;
  logic            q_empty;

  assign full = q_full;

  // front end: opcode tagging and character classification
  clp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .token   (wr_token)
  );

  // token queue decoupling the two halves
  clp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (wr_token),
    .rd      (q_rd),
    .rd_data (rd_token),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back end: argument accumulation, range checks, output register
  clp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!q_empty),
    .token     (rd_token),
    .tok_take  (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

// ===== sv/clp_checker.sv =====
`timescale 1ns / 1ps
`include "ascii_command_line_parser_top_macros.svh"
module clp_checker (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input clp_pkg::out_t out_item
);

  logic        shown;
  logic [2:0]  kind;
  logic [13:0] value;
  logic        rate_ok;
  logic        event_ok;

  assign shown    = !empty;
  assign kind     = out_item.command_kind;
  assign value    = out_item.command_value;
  assign rate_ok  = (value != 14'd0) && (value <= clp_pkg::RATE_MAX);
  assign event_ok = (value <= clp_pkg::EVENT_MAX);

  `CLP_ASSERT_NOW(a_reset_clean, clk, rst, $past(rst), empty && !full)
  `CLP_ASSERT_NEXT(a_stall_hold, clk, rst, shown && !pop, shown && $stable(out_item))
  `CLP_ASSERT_NOW(a_value_zero, clk, rst, shown && kind < clp_pkg::KIND_RATE, value == 14'd0)
  `CLP_ASSERT_NOW(a_rate_range, clk, rst, shown && kind == clp_pkg::KIND_RATE, rate_ok)
  `CLP_ASSERT_NOW(a_event_range, clk, rst, shown && kind == clp_pkg::KIND_EVENT, event_ok)

endmodule

bind ascii_command_line_parser_top clp_checker u_clp_checker (.*);
